FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on clk, off while rstn is low.
`define CSB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("csb checker: property violated");

// Concurrent assertion, sampled on clk, also checked during reset.
`define CSB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("csb checker: property violated");

`endif

FILE: hw/rtl/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Types, sizes and controller codes of the counting sort batch core.
// ----------------------------------------------------------------------------
package csb_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int KEY_BITS   = 8;
  localparam int VALUE_BITS = 16;
  localparam int NUM_BINS   = 1 << KEY_BITS;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W      = $clog2(MAX_ITEMS);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // Input transaction
  typedef struct packed {
    key_t sort_key;
    val_t payload;
    logic batch_end;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    key_t sorted_key;
    val_t sorted_payload;
    logic final_result;
    logic dropped_flag;
    logic empty_batch;
  } out_item_t;

  // One stored element
  typedef struct packed {
    key_t key;
    val_t payload;
  } entry_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FLUSH,
    ST_PREFIX,
    ST_PL_STORE,
    ST_PL_BIN,
    ST_PL_WR,
    ST_DR_RD,
    ST_DR_LD,
    ST_EMPTY
  } csb_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic pfx_init;
    logic pfx_step;
    logic pl_rd_store;
    logic pl_rd_bin;
    logic pl_wr;
    logic dr_rd;
    logic dr_ld;
    logic empty_ld;
    logic batch_clr;
  } csb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic pfx_last;
    logic pl_idx_zero;
    logic dr_last;
    logic out_free;
  } csb_sts_t;

endpackage

FILE: hw/rtl/counting_sort_batch_core.sv
// ----------------------------------------------------------------------------
// counting_sort_batch_core
// Stable counting sort over one batch of up to 64 keyed elements.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one element per cycle while
// loading: key, payload and a batch-end mark. Elements with a key above
// max_key, or arriving when 64 are held, are dropped and flagged.
// After the batch-end transaction the input stalls while the core sorts:
// a flush, running sums over bins 0 to max_key, backward placement of each
// kept element, then a drain of the sorted buffer one result at a time; the
// reads of the item store, histogram and sorted buffer are registered.
// Output channel (out_valid_o / out_stall_i) sends the batch in key order,
// final_result on the last one; an empty batch gives one empty_batch result.
// A stalled result holds in the output register; the drain waits on it.
// The config channel (cfg_valid_i / cfg_ready_o) writes max_key, always ready.
// Reset sets max_key to 255 and empties the batch; histogram bins are cleared
// all together through per-bin valid bits, at reset and after every batch.
// ----------------------------------------------------------------------------
module counting_sort_batch_core import csb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  key_t      cfg_data_i
);

  csb_cmd_t cmd;
  csb_sts_t sts;

  // Sequencer
  csb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.batch_end),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic
  csb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hw/rtl/csb_ctrl.sv
// ----------------------------------------------------------------------------
// csb_ctrl
// Phase sequencer: load, prefix sums, backward placement and drain.
// ----------------------------------------------------------------------------
module csb_ctrl import csb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_stall_o,
  input  csb_sts_t   sts_i,
  output csb_cmd_t   cmd_o
);

  csb_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        // last histogram update lands in this cycle
        cmd_o.pfx_init = 1'b1;
        if (sts_i.count_zero) begin
          state_d = ST_EMPTY;
        end else begin
          state_d = ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        cmd_o.pfx_step = 1'b1;
        if (sts_i.pfx_last) begin
          state_d = ST_PL_STORE;
        end
      end
      ST_PL_STORE: begin
        cmd_o.pl_rd_store = 1'b1;
        state_d           = ST_PL_BIN;
      end
      ST_PL_BIN: begin
        cmd_o.pl_rd_bin = 1'b1;
        state_d         = ST_PL_WR;
      end
      ST_PL_WR: begin
        cmd_o.pl_wr = 1'b1;
        if (sts_i.pl_idx_zero) begin
          state_d = ST_DR_RD;
        end else begin
          state_d = ST_PL_STORE;
        end
      end
      ST_DR_RD: begin
        cmd_o.dr_rd = 1'b1;
        state_d     = ST_DR_LD;
      end
      ST_DR_LD: begin
        if (sts_i.out_free) begin
          cmd_o.dr_ld = 1'b1;
          if (sts_i.dr_last) begin
            cmd_o.batch_clr = 1'b1;
            state_d         = ST_LOAD;
          end else begin
            state_d = ST_DR_RD;
          end
        end
      end
      ST_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.empty_ld  = 1'b1;
          cmd_o.batch_clr = 1'b1;
          state_d         = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

FILE: hw/rtl/csb_dpath.sv
// ----------------------------------------------------------------------------
// csb_dpath
// Item store, histogram RAM, sorted buffer, counters and output register.
// ----------------------------------------------------------------------------
module csb_dpath import csb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  csb_cmd_t  cmd_i,
  output csb_sts_t  sts_o,
  input  in_item_t  in_data_i,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  key_t      cfg_data_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  // Memories
  entry_t store_mem [MAX_ITEMS];
  entry_t sbuf_mem  [MAX_ITEMS];
  cnt_t   bin_mem   [NUM_BINS];

  logic [NUM_BINS-1:0] bin_vld_q;

  key_t      max_key_q;
  cnt_t      count_q;
  logic      drop_q;
  logic      keep;

  // Histogram read and write ports
  logic      bin_re;
  key_t      bin_raddr;
  cnt_t      bin_rd_mem_q;
  logic      bin_rd_vld_q;
  cnt_t      bin_rd;
  logic      bin_we;
  key_t      bin_waddr;
  cnt_t      bin_wdata;
  cnt_t      load_base;

  // Load pipeline and forwarding
  logic      lpend_q;
  key_t      lpend_key_q;
  logic      lw_vld_q;
  key_t      lw_key_q;
  cnt_t      lw_val_q;

  // Prefix pipeline
  logic      ppend_q;
  key_t      ppend_addr_q;
  key_t      pfx_idx_q;
  cnt_t      acc_q;

  // Placement and drain
  idx_t      pl_idx_q;
  entry_t    st_rd_q;
  idx_t      dr_idx_q;
  entry_t    sb_rd_q;

  out_item_t out_q;
  logic      out_valid_q;
  logic      out_free;
  logic      dr_last;

  assign cfg_ready_o = 1'b1;

  assign keep = cmd_i.load && (in_data_i.sort_key <= max_key_q)
             && (count_q != CNT_W'(MAX_ITEMS));

  assign bin_rd = bin_rd_vld_q ? bin_rd_mem_q : '0;

  // Pick the histogram read address
  always_comb begin
    bin_re    = keep || cmd_i.pfx_step || cmd_i.pl_rd_bin;
    bin_raddr = st_rd_q.key;
    if (keep) begin
      bin_raddr = in_data_i.sort_key;
    end else if (cmd_i.pfx_step) begin
      bin_raddr = pfx_idx_q;
    end
  end

  // Pick the histogram write: count, running sum or placement decrement
  always_comb begin
    load_base = (lw_vld_q && (lw_key_q == lpend_key_q)) ? lw_val_q : bin_rd;
    bin_we    = 1'b0;
    bin_waddr = lpend_key_q;
    bin_wdata = load_base + CNT_W'(1);
    if (lpend_q) begin
      bin_we = 1'b1;
    end else if (ppend_q) begin
      bin_we    = 1'b1;
      bin_waddr = ppend_addr_q;
      bin_wdata = acc_q + bin_rd;
    end else if (cmd_i.pl_wr) begin
      bin_we    = 1'b1;
      bin_waddr = st_rd_q.key;
      bin_wdata = bin_rd - CNT_W'(1);
    end
  end

  // Histogram RAM
  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
    if (bin_re) begin
      bin_rd_mem_q <= bin_mem[bin_raddr];
      bin_rd_vld_q <= bin_vld_q[bin_raddr];
    end
  end

  // Item store
  always_ff @(posedge clk_i) begin
    if (keep) begin
      store_mem[count_q[IDX_W-1:0]] <= '{key: in_data_i.sort_key, payload: in_data_i.payload};
    end
    if (cmd_i.pl_rd_store) begin
      st_rd_q <= store_mem[pl_idx_q];
    end
  end

  // Sorted buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.pl_wr) begin
      sbuf_mem[bin_wdata[IDX_W-1:0]] <= st_rd_q;
    end
    if (cmd_i.dr_rd) begin
      sb_rd_q <= sbuf_mem[dr_idx_q];
    end
  end

  assign dr_last  = CNT_W'(dr_idx_q) == (count_q - CNT_W'(1));
  assign out_free = !out_valid_q || !out_stall_i;

  // Batch state, counters and pipelines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_key_q    <= '1;
      count_q      <= '0;
      drop_q       <= 1'b0;
      bin_vld_q    <= '0;
      lpend_q      <= 1'b0;
      lpend_key_q  <= '0;
      lw_vld_q     <= 1'b0;
      lw_key_q     <= '0;
      lw_val_q     <= '0;
      ppend_q      <= 1'b0;
      ppend_addr_q <= '0;
      pfx_idx_q    <= '0;
      acc_q        <= '0;
      pl_idx_q     <= '0;
      dr_idx_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_key_q <= cfg_data_i;
      end

      // count and drop tracking
      if (cmd_i.batch_clr) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end else if (keep) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.load) begin
        drop_q <= 1'b1;
      end

      // bin valid bits: clear all at batch end, mark on write
      if (cmd_i.batch_clr) begin
        bin_vld_q <= '0;
      end else if (bin_we) begin
        bin_vld_q[bin_waddr] <= 1'b1;
      end

      // hold the last count update for back-to-back same keys
      lpend_q     <= keep;
      lpend_key_q <= in_data_i.sort_key;
      lw_vld_q    <= lpend_q;
      lw_key_q    <= lpend_key_q;
      lw_val_q    <= bin_wdata;

      // running sum sweep
      ppend_q      <= cmd_i.pfx_step;
      ppend_addr_q <= pfx_idx_q;
      if (cmd_i.pfx_init) begin
        pfx_idx_q <= '0;
        acc_q     <= '0;
      end else begin
        if (cmd_i.pfx_step) begin
          pfx_idx_q <= pfx_idx_q + KEY_BITS'(1);
        end
        if (ppend_q) begin
          acc_q <= bin_wdata;
        end
      end

      // placement walks backward, drain walks forward
      if (cmd_i.pfx_init) begin
        pl_idx_q <= IDX_W'(count_q - CNT_W'(1));
        dr_idx_q <= '0;
      end else begin
        if (cmd_i.pl_wr) begin
          pl_idx_q <= pl_idx_q - IDX_W'(1);
        end
        if (cmd_i.dr_ld) begin
          dr_idx_q <= dr_idx_q + IDX_W'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cmd_i.dr_ld) begin
        out_valid_q <= 1'b1;
        out_q       <= '{sorted_key: sb_rd_q.key, sorted_payload: sb_rd_q.payload,
                         final_result: dr_last, dropped_flag: drop_q,
                         empty_batch: 1'b0};
      end else if (cmd_i.empty_ld) begin
        out_valid_q <= 1'b1;
        out_q       <= '{sorted_key: '0, sorted_payload: '0, final_result: 1'b1,
                         dropped_flag: drop_q, empty_batch: 1'b1};
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.count_zero  = count_q == '0;
  assign sts_o.pfx_last    = pfx_idx_q == max_key_q;
  assign sts_o.pl_idx_zero = pl_idx_q == '0;
  assign sts_o.dr_last     = dr_last;
  assign sts_o.out_free    = out_free;

endmodule

FILE: hw/rtl/csb_checker.sv
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks of the counting sort batch core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csb_checker import csb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result holds
  `CSB_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // No new element enters while a batch is still draining
  `CSB_ASSERT(a_no_load_mid_batch, clk_i, rst_ni, out_valid_o && !out_data_o.final_result |-> in_stall_o)

  // A batch-end transaction starts sorting at once
  `CSB_ASSERT(a_end_stalls, clk_i, rst_ni, in_valid_i && !in_stall_o && in_data_i.batch_end |=> in_stall_o)

  // Nothing is offered during reset
  `CSB_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind counting_sort_batch_core csb_checker u_csb_checker (.*);
